// ===== hw/rtl/uics_pkg.sv =====
// Shared constants and types for the UDP/IPv4 checksum stream unit.
// No dependencies; compiled first.
`default_nettype none

package uics_pkg;

    localparam int unsigned C_POS_W  = 17;
    localparam int unsigned C_WORD_W = 16;
    localparam int unsigned C_BYTE_W = 8;
    localparam int unsigned C_SUM_W  = 19;  // room for seven 16-bit operands

    typedef logic [C_POS_W-1:0]  t_pos;
    typedef logic [C_WORD_W-1:0] t_word16;
    typedef logic [C_BYTE_W-1:0] t_byte;

    // Packet byte positions of interest
    localparam t_pos C_POS_MAX      = 17'h1FFFF;
    localparam t_pos C_ADDR_START   = 17'd12;   // source address, first byte
    localparam t_pos C_UDP_START    = 17'd20;   // first datagram byte
    localparam t_pos C_LEN_HI_POS   = 17'd24;
    localparam t_pos C_LEN_LO_POS   = 17'd25;
    localparam t_pos C_CKS_HI_POS   = 17'd26;   // UDP checksum field, high byte
    localparam t_pos C_CKS_LO_POS   = 17'd27;   // UDP checksum field, low byte

    localparam t_word16 C_PROTO_UDP = 16'd17;

endpackage : uics_pkg

`default_nettype wire

// ===== hw/rtl/uics_if.sv =====
// Valid/ready channel interfaces: packet bytes in, checksum results out.
// Depends on uics_pkg.
`default_nettype none

interface uics_byte_if
    import uics_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : uics_byte_if

interface uics_result_if
    import uics_pkg::*;
();
    logic    valid;
    logic    ready;
    t_word16 checksum;
    logic    truncated;

    modport source (output valid, output checksum, output truncated, input ready);
    modport sink   (input valid, input checksum, input truncated, output ready);
endinterface : uics_result_if

`default_nettype wire

// ===== hw/rtl/udp_ipv4_checksum_stream_unit.sv =====
// Top level of the UDP/IPv4 checksum stream unit.
// Depends on uics_pkg, uics_if, uics_in_reg and uics_sum.
//
// Usage:
//   i_byte   carries one packet as a stream of words, one byte per word: a
//            20-byte IPv4 header without options, then the UDP datagram.
//            last_byte marks the final word of a packet.
//   o_result carries one word per packet: the inverted ones' complement sum
//            of the pseudoheader and the datagram (checksum field as zero),
//            and a truncated flag when the packet ends before the UDP length
//            is covered. A packet ending before the length field gives
//            checksum zero with truncated set.
// Throughput: one input word per cycle, sustained across packet boundaries.
//   The only stall on i_byte is a final word meeting an untaken result.
// Path: a final word is held in the input register, whose word the
//   accumulate stage folds into the result reg.
// Stall: a held result keeps its value until taken; non-final words keep
//   flowing meanwhile, so only the next packet's final word waits.
// Reset: i_rst_n synchronous, active low; clears the input and result
//   valids and all per-packet state. Packet state also clears after each
//   final word.
`default_nettype none

module udp_ipv4_checksum_stream_unit
    import uics_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    uics_byte_if.sink     i_byte,
    uics_result_if.source o_result
);

    // registered word between input stage and accumulator
    uics_byte_if w_byte ();

    uics_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .o_byte  (w_byte.source)
    );

    // accumulate, track packet position, hold the result word
    uics_sum u_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (w_byte.sink),
        .o_result (o_result)
    );

endmodule : udp_ipv4_checksum_stream_unit

`default_nettype wire

// ===== hw/rtl/uics_in_reg.sv =====
// Input register stage for the byte channel.
// Depends on uics_pkg and uics_byte_if.
`default_nettype none

module uics_in_reg
    import uics_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    uics_byte_if.sink   i_byte,
    uics_byte_if.source o_byte
);

    logic  r_valid;
    t_byte r_data;
    logic  r_last;

    // take a new word when empty or when the held one moves on
    assign i_byte.ready = !r_valid || o_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_valid <= 1'b1;
        end else if (o_byte.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_data <= i_byte.data_byte;
            r_last <= i_byte.last_byte;
        end
    end

    assign o_byte.valid     = r_valid;
    assign o_byte.data_byte = r_data;
    assign o_byte.last_byte = r_last;

endmodule : uics_in_reg

`default_nettype wire

// ===== hw/rtl/uics_sum.sv =====
// Per-byte checksum accumulation, packet state and result register.
// Depends on uics_pkg, uics_byte_if and uics_result_if.
`default_nettype none

module uics_sum
    import uics_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    uics_byte_if.sink     i_byte,
    uics_result_if.source o_result
);

    t_pos              r_pos;
    t_word16           r_sum;
    t_byte             r_pend;
    t_word16           r_len;
    logic [31:0]       r_head;

    logic              r_out_valid;
    t_word16           r_cks;
    logic              r_trunc;

    logic              fire;
    t_byte             b;
    t_word16           wb;
    t_word16           n_len;
    t_word16           len_eff;
    t_pos              dgram_end;
    logic              in_addr;
    logic              in_dgram;
    t_word16           op_byte;
    t_word16           op_proto;
    t_word16           op_len;
    t_word16           op_w0;
    t_word16           op_w1;
    t_word16           op_w2;
    logic [C_SUM_W-1:0] raw;
    logic [16:0]       fold1;
    t_word16           n_sum;
    t_pos              n_pos;
    logic              n_trunc;
    t_word16           n_cks;

    // a non-final word never needs the result slot
    assign i_byte.ready = !i_byte.last_byte || !r_out_valid || o_result.ready;
    assign fire         = i_byte.valid && i_byte.ready;

    always_comb begin
        b         = i_byte.data_byte;
        wb        = r_pos[0] ? {8'h00, b} : {b, 8'h00};
        n_len     = {r_pend, b};
        len_eff   = (r_pos == C_LEN_LO_POS) ? n_len : r_len;
        dgram_end = {1'b0, r_len} + C_UDP_START;

        in_addr  = (r_pos >= C_ADDR_START) && (r_pos < C_UDP_START);
        in_dgram = (r_pos > C_LEN_LO_POS) && (r_pos < C_POS_MAX) && (r_pos < dgram_end)
                   && (r_pos != C_CKS_HI_POS) && (r_pos != C_CKS_LO_POS);

        op_byte  = (in_addr || in_dgram) ? wb : '0;
        op_proto = '0;
        op_len   = '0;
        op_w0    = '0;
        op_w1    = '0;
        op_w2    = '0;
        // length known: add pseudoheader tail and the held UDP header bytes
        if (r_pos == C_LEN_LO_POS) begin
            op_proto = C_PROTO_UDP;
            op_len   = n_len;
            op_w0    = {(n_len >= 16'd1) ? r_head[31:24] : 8'h00,
                        (n_len >= 16'd2) ? r_head[23:16] : 8'h00};
            op_w1    = {(n_len >= 16'd3) ? r_head[15:8]  : 8'h00,
                        (n_len >= 16'd4) ? r_head[7:0]   : 8'h00};
            op_w2    = {(n_len >= 16'd5) ? r_pend        : 8'h00,
                        (n_len >= 16'd6) ? b             : 8'h00};
        end

        raw = {3'b000, r_sum} + {3'b000, op_byte} + {3'b000, op_proto}
            + {3'b000, op_len} + {3'b000, op_w0} + {3'b000, op_w1} + {3'b000, op_w2};
        // end-around carry, twice covers the three carry bits
        fold1 = {1'b0, raw[15:0]} + {14'd0, raw[18:16]};
        n_sum = fold1[15:0] + {15'd0, fold1[16]};

        n_pos = (r_pos < C_POS_MAX) ? r_pos + 17'd1 : r_pos;

        if (n_pos <= C_LEN_LO_POS) begin
            n_trunc = 1'b1;
            n_cks   = '0;
        end else begin
            n_trunc = n_pos < ({1'b0, len_eff} + C_UDP_START);
            n_cks   = ~n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_pend <= '0;
            r_len  <= '0;
            r_head <= '0;
        end else if (fire) begin
            if (i_byte.last_byte) begin
                // drop all packet state for the next packet
                r_pos  <= '0;
                r_sum  <= '0;
                r_pend <= '0;
                r_len  <= '0;
                r_head <= '0;
            end else begin
                r_pos <= n_pos;
                r_sum <= n_sum;
                if ((r_pos >= C_UDP_START) && (r_pos < C_LEN_HI_POS)) begin
                    r_head <= {r_head[23:0], b};
                end
                if (r_pos == C_LEN_HI_POS) begin
                    r_pend <= b;
                end
                if (r_pos == C_LEN_LO_POS) begin
                    r_len <= n_len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && i_byte.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_byte.last_byte) begin
            r_cks   <= n_cks;
            r_trunc <= n_trunc;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.checksum  = r_cks;
    assign o_result.truncated = r_trunc;

`ifndef SYNTHESIS
    a_pos_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_byte.last_byte) |=> (r_pos == '0))
        else $error("byte position not cleared after final word");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(fire && i_byte.last_byte))
        else $error("result raised without a final word");

    a_sum_zero_before_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= C_ADDR_START) |-> (r_sum == '0))
        else $error("running sum nonzero before address bytes");
`endif

endmodule : uics_sum

`default_nettype wire

// ===== bench/uics_checksum_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the UDP/IPv4 checksum stream unit: folds each accepted packet
// byte into its own checksum and compares every result word against it.
// Depends on uics_pkg and uics_if.

module uics_checksum_checker
    import uics_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    uics_byte_if   i_byte,
    uics_result_if i_result,
    output int     o_fail_count,
    output int     o_pending
);

    typedef struct packed {
        t_word16 checksum;
        logic    truncated;
    } t_cks_result;

    // Per-packet state of the predictor
    t_pos        pkt_pos;
    t_word16     ones_sum;
    t_byte       len_hi;
    t_word16     udp_len;
    logic [31:0] udp_head;

    t_cks_result expected_sums[$];
    int          mismatch_count = 0;

    function automatic t_word16 ones_add(input t_word16 a, input t_word16 b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Even packet offsets carry the high byte of a big-endian word.
    function automatic t_word16 weigh_byte(input t_pos pos, input t_byte b);
        return pos[0] ? {8'h00, b} : {b, 8'h00};
    endfunction

    task automatic clear_packet();
        pkt_pos  = '0;
        ones_sum = '0;
        len_hi   = '0;
        udp_len  = '0;
        udp_head = '0;
    endtask

    // Drop bytes past the UDP length and the checksum field itself.
    task automatic add_datagram_byte(input t_pos pos, input t_byte b);
        t_pos off;
        off = pos - C_UDP_START;
        if (off < {1'b0, udp_len} && off != C_CKS_HI_POS - C_UDP_START
                && off != C_CKS_LO_POS - C_UDP_START)
            ones_sum = ones_add(ones_sum, weigh_byte(pos, b));
    endtask

    task automatic fold_packet_byte(input t_byte b, input logic last);
        t_cks_result res;
        if (pkt_pos >= C_ADDR_START && pkt_pos < C_UDP_START) begin
            ones_sum = ones_add(ones_sum, weigh_byte(pkt_pos, b));
        end else if (pkt_pos >= C_UDP_START && pkt_pos < C_LEN_HI_POS) begin
            udp_head = {udp_head[23:0], b};
        end else if (pkt_pos == C_LEN_HI_POS) begin
            len_hi = b;
        end else if (pkt_pos == C_LEN_LO_POS) begin
            // Length known: add pseudoheader tail, then the held UDP header bytes
            udp_len  = {len_hi, b};
            ones_sum = ones_add(ones_sum, C_PROTO_UDP);
            ones_sum = ones_add(ones_sum, udp_len);
            for (int k = 0; k < 4; k++)
                add_datagram_byte(C_UDP_START + t_pos'(k), udp_head[31-8*k -: 8]);
            add_datagram_byte(C_LEN_HI_POS, len_hi);
            add_datagram_byte(C_LEN_LO_POS, b);
        end else if (pkt_pos > C_LEN_LO_POS && pkt_pos < C_POS_MAX) begin
            add_datagram_byte(pkt_pos, b);
        end
        if (pkt_pos != C_POS_MAX)
            pkt_pos++;
        if (last) begin
            if (pkt_pos <= C_LEN_LO_POS) begin
                res.checksum  = '0;
                res.truncated = 1'b1;
            end else begin
                res.checksum  = ~ones_sum;
                res.truncated = (32'(pkt_pos) < 32'(C_UDP_START) + 32'(udp_len));
            end
            expected_sums.push_back(res);
            clear_packet();
        end
    endtask

    always @(posedge i_clk) begin : score_proc
        t_cks_result want;
        if (!i_rst_n) begin
            clear_packet();
            expected_sums.delete();
        end else begin
            // Check the result first: a byte taken on this edge cannot own it
            if (i_result.valid && i_result.ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result checksum %h truncated %b", $time,
                             i_result.checksum, i_result.truncated);
                    mismatch_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (i_result.checksum !== want.checksum) begin
                        $display("%0t: checksum expected %h actual %h", $time,
                                 want.checksum, i_result.checksum);
                        mismatch_count++;
                    end
                    if (i_result.truncated !== want.truncated) begin
                        $display("%0t: truncated expected %b actual %b", $time,
                                 want.truncated, i_result.truncated);
                        mismatch_count++;
                    end
                end
            end
            if (i_byte.valid && i_byte.ready)
                fold_packet_byte(i_byte.data_byte, i_byte.last_byte);
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_sums.size();
    end

endmodule : uics_checksum_checker

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the bench for the UDP/IPv4 checksum stream unit: drives packets and
// result back-pressure, and gives the verdict from the checker's count.
// Depends on uics_pkg, uics_if, the unit itself and uics_checksum_checker.

module tb_top;
    import uics_pkg::*;

    typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} t_fill;

    logic clk;
    logic rst_n;

    uics_byte_if   byte_ch ();
    uics_result_if result_ch ();

    int          fail_count;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int unsigned bytes_sent   = 0;
    int unsigned packets_sent = 0;

    udp_ipv4_checksum_stream_unit u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    uics_checksum_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_byte       (byte_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run, even with the heavily idled phases.
    initial begin
        #(100_000 * 10);
        $display("Test completed with failures");
        $finish;
    end

    // Result back-pressure: drop ready on a random rx_idle_pct percent of cycles.
    always @(posedge clk) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one word, with random idle cycles ahead of it. Valid stays high
    // into the next call, so back-to-back words get a single assignment.
    task automatic send_byte(input t_byte b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // One packet of 'total' words. The UDP length field sits at bytes 24..25
    // whenever the packet reaches them; every other byte follows 'fill'.
    task automatic send_packet(input t_word16 len_field, input int unsigned total,
                               input t_fill fill);
        t_byte b;
        for (int unsigned i = 0; i < total; i++) begin
            if (i == C_LEN_HI_POS) begin
                b = len_field[15:8];
            end else if (i == C_LEN_LO_POS) begin
                b = len_field[7:0];
            end else begin
                case (fill)
                    FILL_ZEROS: b = '0;
                    FILL_ONES:  b = '1;
                    default:    b = t_byte'($urandom);
                endcase
            end
            send_byte(b, i == total - 1);
        end
        packets_sent++;
    endtask

    // Mostly well-formed datagrams, the rest short lengths, truncation and
    // packets whose length field is noise.
    task automatic send_random_packet();
        int unsigned kind;
        int unsigned len;
        int unsigned extra;
        kind = $urandom_range(99);
        if (kind < 70) begin
            len   = $urandom_range(48, 8);
            extra = ($urandom_range(3) == 0) ? $urandom_range(8, 1) : 0;
            send_packet(t_word16'(len), 20 + len + extra, FILL_RANDOM);
        end else if (kind < 80) begin
            len = $urandom_range(7, 0);
            send_packet(t_word16'(len), $urandom_range(36, 26), FILL_RANDOM);
        end else if (kind < 90) begin
            len = $urandom_range(60, 8);
            send_packet(t_word16'(len), $urandom_range(19 + len, 26), FILL_RANDOM);
        end else if (kind < 95) begin
            send_packet(t_word16'($urandom), $urandom_range(25, 1), FILL_RANDOM);
        end else begin
            send_packet(t_word16'($urandom), $urandom_range(70, 26), FILL_RANDOM);
        end
    endtask

    initial begin : stimulus
        int unsigned phase_bytes;
        int unsigned phase_packets;
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.last_byte <= 1'b0;
        tx_idle_pct = 17;
        rx_idle_pct = 83;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 17; rx_idle_pct = 83; end
                1:       begin tx_idle_pct = 83; rx_idle_pct = 17; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase

            if (phase == 0) begin
                // Packet ends before the length field: checksum zero, truncated
                send_packet(16'd8, 1, FILL_RANDOM);
                send_packet(16'd8, 25, FILL_RANDOM);
                // Length known but the datagram cut short
                send_packet(16'd8, 26, FILL_RANDOM);
                // Minimal complete datagram, with data extremes
                send_packet(16'd8, 28, FILL_RANDOM);
                send_packet(16'd8, 28, FILL_ONES);
                send_packet(16'd8, 28, FILL_ZEROS);
                // Length below eight: only bytes under the length count
                send_packet(16'd0, 30, FILL_RANDOM);
                send_packet(16'd3, 26, FILL_RANDOM);
                send_packet(16'd5, 40, FILL_RANDOM);
                send_packet(16'd7, 27, FILL_RANDOM);
                // Odd length: trailing byte padded low
                send_packet(16'd9, 29, FILL_RANDOM);
                // Truncated on a lone high byte
                send_packet(16'd20, 31, FILL_RANDOM);
                // Bytes past the datagram are ignored
                send_packet(16'd12, 42, FILL_RANDOM);
                // Largest length field, far from covered
                send_packet(16'hFFFF, 40, FILL_ONES);
                send_packet(16'd48, 68, FILL_RANDOM);
            end

            phase_bytes   = bytes_sent;
            phase_packets = packets_sent;
            while (bytes_sent - phase_bytes < 400 || packets_sent - phase_packets < 8)
                send_random_packet();
        end

        // Drain: hold valid low until every result is in, then a short tail
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule : tb_top
